// File: design/aabb_pkg.sv
package aabb_pkg;

    localparam int MAX_BOXES    = 64;
    localparam int COORD_BITS   = 32;
    localparam int IDX_BITS     = $clog2(MAX_BOXES);
    localparam int CNT_BITS     = $clog2(MAX_BOXES + 1);
    localparam int IN_BITS      = 32;
    localparam int OUT_IDX_BITS = 6;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]          idx_t;
    typedef logic [CNT_BITS-1:0]          cnt_t;

    localparam cnt_t FULL_COUNT = cnt_t'(MAX_BOXES);

    typedef struct packed {
        coord_t min_x;
        coord_t max_x;
        coord_t min_y;
        coord_t max_y;
        coord_t min_z;
        coord_t max_z;
    } box_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DROP
    } state_t;

endpackage

// File: design/aabb_cmp.sv
module aabb_cmp
    import aabb_pkg::*;
(
    input  box_t stored_box,
    input  box_t probe_box,
    output logic hit
);

    logic hit_x;
    logic hit_y;
    logic hit_z;

    assign hit_x = (stored_box.min_x <= probe_box.max_x) && (probe_box.min_x <= stored_box.max_x);
    assign hit_y = (stored_box.min_y <= probe_box.max_y) && (probe_box.min_y <= stored_box.max_y);
    assign hit_z = (stored_box.min_z <= probe_box.max_z) && (probe_box.min_z <= stored_box.max_z);
    assign hit   = hit_x && hit_y && hit_z;

endmodule

// File: design/aabb_brute_force_pair_finder.sv
// Brute-force box pair finder. Each accepted word is one box; the block stores
// it at the next index of the current set and tests it against every earlier
// box, one stored entry per cycle through the single read port of the box
// memory while m_ready does not hold a result back. An accepted box keeps
// s_ready low until its scan ends and its last pair, or its drop word, is
// registered for output; no new box is taken before that. Overlaps
// come out as (earlier, later) words in ascending earlier index, the final
// one of each item marked with m_last. A box sent while the store holds
// MAX_BOXES entries (and s_start_set is low) is dropped and answered with a
// single word carrying m_dropped and m_last.
module aabb_brute_force_pair_finder
    import aabb_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_start_set,
    input  logic signed [IN_BITS-1:0]      s_min_x,
    input  logic signed [IN_BITS-1:0]      s_max_x,
    input  logic signed [IN_BITS-1:0]      s_min_y,
    input  logic signed [IN_BITS-1:0]      s_max_y,
    input  logic signed [IN_BITS-1:0]      s_min_z,
    input  logic signed [IN_BITS-1:0]      s_max_z,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [OUT_IDX_BITS-1:0]        m_earlier_index,
    output logic [OUT_IDX_BITS-1:0]        m_later_index,
    output logic                           m_dropped,
    output logic                           m_last
);

    state_t state_reg, state_next;

    cnt_t   box_count_reg, box_count_next;
    cnt_t   newi_reg, newi_next;
    cnt_t   addr_reg, addr_next;
    logic   data_vld_reg, data_vld_next;
    idx_t   data_idx_reg, data_idx_next;
    logic   pend_vld_reg, pend_vld_next;
    idx_t   pend_idx_reg, pend_idx_next;
    box_t   probe_reg, probe_next;
    box_t   rd_data_reg;

    logic                    m_valid_reg, m_valid_next;
    logic [OUT_IDX_BITS-1:0] m_earlier_index_reg, m_earlier_index_next;
    logic [OUT_IDX_BITS-1:0] m_later_index_reg, m_later_index_next;
    logic                    m_dropped_reg, m_dropped_next;
    logic                    m_last_reg, m_last_next;

    box_t   box_mem [MAX_BOXES];

    box_t   in_box;
    cnt_t   in_newi;
    logic   in_full;
    logic   accept;
    logic   wr_en;
    logic   rd_en;
    logic   hit;
    logic   out_free;
    logic   consume;
    logic   advance;
    logic   scan_done;

    assign in_box.min_x = coord_t'(s_min_x);
    assign in_box.max_x = coord_t'(s_max_x);
    assign in_box.min_y = coord_t'(s_min_y);
    assign in_box.max_y = coord_t'(s_max_y);
    assign in_box.min_z = coord_t'(s_min_z);
    assign in_box.max_z = coord_t'(s_max_z);

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_newi  = s_start_set ? '0 : box_count_reg;
    assign in_full  = (in_newi == FULL_COUNT);
    assign wr_en    = accept && !in_full;
    assign out_free = !m_valid_reg || m_ready;

    aabb_cmp u_cmp (
        .stored_box (rd_data_reg),
        .probe_box  (probe_reg),
        .hit        (hit)
    );

    assign consume   = (state_reg == ST_SCAN) && data_vld_reg
                       && (!hit || !pend_vld_reg || out_free);
    assign advance   = (state_reg == ST_SCAN) && (!data_vld_reg || consume);
    assign rd_en     = advance && (addr_reg < newi_reg);
    assign scan_done = (state_reg == ST_SCAN) && !data_vld_reg && (addr_reg == newi_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = in_full ? ST_DROP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_vld_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DROP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        box_count_next       = box_count_reg;
        newi_next            = newi_reg;
        addr_next            = addr_reg;
        data_vld_next        = data_vld_reg;
        data_idx_next        = data_idx_reg;
        pend_vld_next        = pend_vld_reg;
        pend_idx_next        = pend_idx_reg;
        probe_next           = probe_reg;
        m_valid_next         = m_valid_reg;
        m_earlier_index_next = m_earlier_index_reg;
        m_later_index_next   = m_later_index_reg;
        m_dropped_next       = m_dropped_reg;
        m_last_next          = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    probe_next    = in_box;
                    newi_next     = in_newi;
                    addr_next     = '0;
                    data_vld_next = 1'b0;
                    pend_vld_next = 1'b0;
                    if (!in_full) begin
                        box_count_next = in_newi + cnt_t'(1);
                    end else begin
                        box_count_next = in_newi;
                    end
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    data_vld_next = rd_en;
                    if (rd_en) begin
                        data_idx_next = addr_reg[IDX_BITS-1:0];
                        addr_next     = addr_reg + cnt_t'(1);
                    end
                end
                if (consume && hit) begin
                    if (pend_vld_reg) begin
                        m_valid_next         = 1'b1;
                        m_earlier_index_next = OUT_IDX_BITS'(pend_idx_reg);
                        m_later_index_next   = OUT_IDX_BITS'(newi_reg);
                        m_dropped_next       = 1'b0;
                        m_last_next          = 1'b0;
                    end
                    pend_vld_next = 1'b1;
                    pend_idx_next = data_idx_reg;
                end
            end
            ST_FLUSH: begin
                if (pend_vld_reg && out_free) begin
                    m_valid_next         = 1'b1;
                    m_earlier_index_next = OUT_IDX_BITS'(pend_idx_reg);
                    m_later_index_next   = OUT_IDX_BITS'(newi_reg);
                    m_dropped_next       = 1'b0;
                    m_last_next          = 1'b1;
                    pend_vld_next        = 1'b0;
                end
            end
            ST_DROP: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_earlier_index_next = '0;
                    m_later_index_next   = '0;
                    m_dropped_next       = 1'b1;
                    m_last_next          = 1'b1;
                end
            end
            default: begin
                pend_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            box_count_reg <= '0;
            data_vld_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            data_vld_reg  <= data_vld_next;
            pend_vld_reg  <= pend_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        newi_reg            <= newi_next;
        addr_reg            <= addr_next;
        data_idx_reg        <= data_idx_next;
        pend_idx_reg        <= pend_idx_next;
        probe_reg           <= probe_next;
        m_earlier_index_reg <= m_earlier_index_next;
        m_later_index_reg   <= m_later_index_next;
        m_dropped_reg       <= m_dropped_next;
        m_last_reg          <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            box_mem[in_newi[IDX_BITS-1:0]] <= in_box;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= box_mem[addr_reg[IDX_BITS-1:0]];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_earlier_index = m_earlier_index_reg;
    assign m_later_index   = m_later_index_reg;
    assign m_dropped       = m_dropped_reg;
    assign m_last          = m_last_reg;

    a_drop_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> m_last)
        else $error("dropped word without last");

    a_start_resets_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_start_set |=> box_count_reg == cnt_t'(1))
        else $error("start of set did not restart the box count");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        box_count_reg <= FULL_COUNT)
        else $error("box count beyond store depth");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_vld_reg)
        else $error("pending pair left behind at idle");

    a_read_below_new: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && data_vld_reg |-> cnt_t'(data_idx_reg) < newi_reg)
        else $error("scan read an entry at or above the new index");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import aabb_pkg::*;

    typedef struct packed {
        logic [OUT_IDX_BITS-1:0] earlier;
        logic [OUT_IDX_BITS-1:0] later;
        logic                    dropped;
        logic                    last;
    } pair_t;

    localparam int MAX_FAIL_SHOW = 10;
    localparam int DRAIN_CYCLES  = MAX_BOXES + 40;
    localparam int RANDOM_ITEMS  = 185;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_start_set;
    logic signed [IN_BITS-1:0] s_min_x;
    logic signed [IN_BITS-1:0] s_max_x;
    logic signed [IN_BITS-1:0] s_min_y;
    logic signed [IN_BITS-1:0] s_max_y;
    logic signed [IN_BITS-1:0] s_min_z;
    logic signed [IN_BITS-1:0] s_max_z;
    logic                    m_valid;
    logic                    m_ready;
    logic [OUT_IDX_BITS-1:0] m_earlier_index;
    logic [OUT_IDX_BITS-1:0] m_later_index;
    logic                    m_dropped;
    logic                    m_last;

    box_t  stored_boxes [MAX_BOXES];
    int    stored_cnt = 0;
    pair_t pair_q [$];

    int  fail_cnt    = 0;
    int  boxes_sent  = 0;
    int  sets_begun  = 0;
    int  pairs_seen  = 0;
    int  drops_seen  = 0;
    bit  steady_src  = 1'b0;
    bit  steady_sink = 1'b0;

    aabb_brute_force_pair_finder i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_set     (s_start_set),
        .s_min_x         (s_min_x),
        .s_max_x         (s_max_x),
        .s_min_y         (s_min_y),
        .s_max_y         (s_max_y),
        .s_min_z         (s_min_z),
        .s_max_z         (s_max_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_earlier_index (m_earlier_index),
        .m_later_index   (m_later_index),
        .m_dropped       (m_dropped),
        .m_last          (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void note_fail(string msg);
        if (fail_cnt < MAX_FAIL_SHOW) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        fail_cnt++;
    endfunction

    function automatic string fmt_pair(pair_t p);
        return $sformatf("earlier=%0d later=%0d dropped=%0b last=%0b",
                         p.earlier, p.later, p.dropped, p.last);
    endfunction

    function automatic bit boxes_meet(box_t a, box_t b);
        return ($signed(a.min_x) <= $signed(b.max_x)) && ($signed(b.min_x) <= $signed(a.max_x))
            && ($signed(a.min_y) <= $signed(b.max_y)) && ($signed(b.min_y) <= $signed(a.max_y))
            && ($signed(a.min_z) <= $signed(b.max_z)) && ($signed(b.min_z) <= $signed(a.max_z));
    endfunction

    function automatic void queue_word(pair_t p);
        pair_q.insert(pair_q.size(), p);
    endfunction

    function automatic void predict_pairs(bit start, box_t b);
        pair_t p;
        int    hits;
        int    i;
        if (start) begin
            stored_cnt = 0;
        end
        if (stored_cnt >= MAX_BOXES) begin
            p.earlier = '0;
            p.later   = '0;
            p.dropped = 1'b1;
            p.last    = 1'b1;
            queue_word(p);
            return;
        end
        hits = 0;
        for (i = 0; i < stored_cnt; i++) begin
            if (boxes_meet(stored_boxes[i], b)) begin
                p.earlier = OUT_IDX_BITS'(i);
                p.later   = OUT_IDX_BITS'(stored_cnt);
                p.dropped = 1'b0;
                p.last    = 1'b0;
                queue_word(p);
                hits++;
            end
        end
        if (hits > 0) begin
            pair_q[pair_q.size() - 1].last = 1'b1;
        end
        stored_boxes[stored_cnt] = b;
        stored_cnt++;
    endfunction

    function automatic int pick_gap(bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic box_t cube(coord_t lo, coord_t hi);
        box_t b;
        b.min_x = lo;
        b.max_x = hi;
        b.min_y = lo;
        b.max_y = hi;
        b.min_z = lo;
        b.max_z = hi;
        return b;
    endfunction

    function automatic coord_t pick_center();
        int c;
        case ($urandom_range(0, 3))
            0: c = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            1: c = 32'h7FFF_FFFF - $urandom_range(0, 32'h0004_0000);
            2: c = 32'h8000_0000 + $urandom_range(0, 32'h0004_0000);
            default: c = $urandom;
        endcase
        return coord_t'(c);
    endfunction

    function automatic void pick_span(coord_t c, int spread, output coord_t lo,
                                      output coord_t hi);
        coord_t a;
        coord_t z;
        a = c + coord_t'($urandom_range(0, spread)) - coord_t'(spread / 2);
        z = a + coord_t'($urandom_range(0, spread));
        if ($urandom_range(0, 19) == 0) begin
            lo = z;
            hi = a;
        end else begin
            lo = a;
            hi = z;
        end
    endfunction

    function automatic box_t cluster_box(coord_t cx, coord_t cy, coord_t cz, int spread);
        box_t b;
        pick_span(cx, spread, b.min_x, b.max_x);
        pick_span(cy, spread, b.min_y, b.max_y);
        pick_span(cz, spread, b.min_z, b.max_z);
        return b;
    endfunction

    function automatic box_t noise_box();
        box_t b;
        b.min_x = $urandom;
        b.max_x = $urandom;
        b.min_y = $urandom;
        b.max_y = $urandom;
        b.min_z = $urandom;
        b.max_z = $urandom;
        return b;
    endfunction

    task automatic send_box(input bit start, input box_t b);
        int gap;
        gap = pick_gap(steady_src);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_set <= start;
        s_min_x     <= b.min_x;
        s_max_x     <= b.max_x;
        s_min_y     <= b.min_y;
        s_max_y     <= b.max_y;
        s_min_z     <= b.min_z;
        s_max_z     <= b.max_z;
        do @(posedge aclk); while (!s_ready);
        predict_pairs(start, b);
        boxes_sent++;
        if (start) begin
            sets_begun++;
        end
    endtask

    task automatic test_extreme_boxes();
        send_box(1'b1, cube(32'sh8000_0000, 32'sh7FFF_FFFF));
        send_box(1'b0, cube(32'sh8000_0000, 32'sh8000_0000));
        send_box(1'b0, cube(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_box(1'b0, cube(32'sh8000_0000, 32'sh7FFF_FFFF));
        send_box(1'b0, cube(-32'sh1, 32'sh0));
    endtask

    task automatic test_touch_and_invert();
        box_t b;
        send_box(1'b1, cube(32'sh0, 32'sh1_0000));
        b = cube(32'sh0, 32'sh1_0000);
        b.min_x = 32'sh1_0000;
        b.max_x = 32'sh2_0000;
        send_box(1'b0, b);
        b.min_x = 32'sh2_0001;
        b.max_x = 32'sh3_0000;
        send_box(1'b0, b);
        b.min_x = 32'sh3_0000;
        b.max_x = 32'sh0;
        send_box(1'b0, b);
        b.min_x = -32'sh1_0000;
        b.max_x = 32'sh4_0000;
        send_box(1'b0, b);
    endtask

    task automatic test_no_overlap();
        box_t b;
        send_box(1'b1, cube(-32'sh1_0000, -32'sh1));
        send_box(1'b0, cube(32'sh0, 32'sh1_0000));
        send_box(1'b0, cube(-32'sh1, 32'sh0));
        b = cube(-32'sh1_0000, 32'sh1_0000);
        b.min_z = 32'sh5_0000;
        b.max_z = 32'sh6_0000;
        send_box(1'b0, b);
        send_box(1'b0, cube(32'sh1, -32'sh1));
        // restart mid-set: the old entries must not match
        send_box(1'b1, cube(32'sh0, 32'sh1_0000));
        send_box(1'b0, cube(32'sh0, 32'sh1_0000));
    endtask

    task automatic test_full_store();
        coord_t cx;
        coord_t cy;
        coord_t cz;
        int     i;
        cx = pick_center();
        cy = pick_center();
        cz = pick_center();
        for (i = 0; i < MAX_BOXES; i++) begin
            send_box(i == 0, cluster_box(cx, cy, cz, 32'h0004_0000));
        end
        repeat (3) send_box(1'b0, cluster_box(cx, cy, cz, 32'h0004_0000));
        send_box(1'b1, cluster_box(cx, cy, cz, 32'h0004_0000));
        send_box(1'b0, cluster_box(cx, cy, cz, 32'h0004_0000));
    endtask

    task automatic test_random_sets(input int n_items);
        int     sent;
        int     len;
        int     i;
        int     r;
        int     spread;
        bit     noisy;
        bit     start;
        coord_t cx;
        coord_t cy;
        coord_t cz;
        box_t   b;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                len = $urandom_range(1, 12);
            end else if (r < 95) begin
                len = $urandom_range(13, 40);
            end else begin
                len = $urandom_range(60, 70);
            end
            if (len > n_items - sent) begin
                len = n_items - sent;
            end
            noisy       = ($urandom_range(0, 9) == 0);
            steady_src  = ($urandom_range(0, 4) == 0);
            steady_sink = ($urandom_range(0, 4) == 0);
            spread      = 1 << $urandom_range(8, 20);
            cx          = pick_center();
            cy          = pick_center();
            cz          = pick_center();
            start       = ($urandom_range(0, 6) != 0);
            for (i = 0; i < len; i++) begin
                if (noisy || $urandom_range(0, 19) == 0) begin
                    b = noise_box();
                end else begin
                    b = cluster_box(cx, cy, cz, spread);
                end
                send_box((i == 0) ? start : ($urandom_range(0, 49) == 0), b);
            end
            sent += len;
        end
        steady_src  = 1'b0;
        steady_sink = 1'b0;
    endtask

    always @(posedge aclk) begin : result_check
        pair_t got;
        pair_t want;
        if (aresetn && m_valid && m_ready) begin
            got.earlier = m_earlier_index;
            got.later   = m_later_index;
            got.dropped = m_dropped;
            got.last    = m_last;
            if (pair_q.size() == 0) begin
                note_fail($sformatf("unexpected word: %s", fmt_pair(got)));
            end else begin
                want = pair_q.pop_front();
                if (got !== want) begin
                    note_fail($sformatf("expected %s, got %s", fmt_pair(want), fmt_pair(got)));
                end
                if (want.dropped) begin
                    drops_seen++;
                end else begin
                    pairs_seen++;
                end
            end
        end
    end

    initial begin : sink_driver
        int run;
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            run = $urandom_range(1, 20);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            gap = pick_gap(steady_sink);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        #40_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : run_tests
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_start_set <= 1'b0;
        s_min_x     <= '0;
        s_max_x     <= '0;
        s_min_y     <= '0;
        s_max_y     <= '0;
        s_min_z     <= '0;
        s_max_z     <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_boxes();
        test_touch_and_invert();
        test_no_overlap();
        test_full_store();
        test_random_sets(RANDOM_ITEMS);

        s_valid <= 1'b0;
        while (pair_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb_top: %0d boxes in %0d sets; %0d overlap words and %0d drop words checked",
                 boxes_sent, sets_begun, pairs_seen, drops_seen);
        $display("tb_top: %0d failures", fail_cnt);
        if (fail_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/aabb_pkg.sv
design/aabb_cmp.sv
design/aabb_brute_force_pair_finder.sv
bench/tb_top.sv
